// ===== sv/kabf_pkg.sv =====
`timescale 1ns / 1ps
package kabf_pkg;
	localparam int FracBits = 24;
	localparam int NoiseW = 24;
	localparam int DataW = 32;
	localparam int CfgIdxW = 2;
	localparam logic [NoiseW-1:0] AngleNoiseRst = 24'd16777;
	localparam logic [NoiseW-1:0] BiasNoiseRst = 24'd50332;
	localparam logic [NoiseW-1:0] MeasNoiseRst = 24'd503316;
	localparam logic [CfgIdxW-1:0] RegAngleNoise = 2'd0;
	localparam logic [CfgIdxW-1:0] RegBiasNoise = 2'd1;
	localparam logic [CfgIdxW-1:0] RegMeasNoise = 2'd2;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
		logic signed [65:0] mx;
		logic signed [65:0] mn;
		mx = 66'sh7FFFFFFF;
		mn = -66'sh80000000;
		if (x > mx) return 32'sh7FFFFFFF;
		else if (x < mn) return 32'sh80000000;
		else return x[31:0];
	endfunction

	function automatic logic signed [65:0] rscale(input logic signed [65:0] x);
		logic signed [65:0] r;
		r = x + 66'sd8388608;
		return r >>> FracBits;
	endfunction
endpackage

// ===== sv/kabf_div.sv =====
`timescale 1ns / 1ps
module kabf_div import kabf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [31:0] num,
	input  logic signed [33:0] den,
	output logic done,
	output logic signed [31:0] quo
);
	logic [55:0] num_mag_q;
	logic [33:0] den_mag_q;
	logic [55:0] q_q;
	logic [33:0] rem_q;
	logic neg_q;
	logic busy_q;
	logic [5:0] cnt_q;
	logic [34:0] trial;
	logic [34:0] sh;
	logic signed [57:0] sq;

	assign sh = {rem_q, num_mag_q[55]};
	assign trial = sh - {1'b0, den_mag_q};
	assign sq = neg_q ? -$signed({2'b00, q_q}) : $signed({2'b00, q_q});
	assign quo = (!neg_q && q_q > 56'h7FFFFFFF) ? 32'sh7FFFFFFF :
		(neg_q && q_q > 56'h80000000) ? 32'sh80000000 : sq[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd55;
			end else if (busy_q) begin
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_mag_q <= {(num[31] ? 32'(-num) : 32'(num)), 24'd0};
			den_mag_q <= den[33] ? 34'(-den) : 34'(den);
			neg_q <= num[31] ^ den[33];
			rem_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			num_mag_q <= {num_mag_q[54:0], 1'b0};
			if (!trial[34]) begin
				rem_q <= trial[33:0];
				q_q <= {q_q[54:0], 1'b1};
			end else begin
				rem_q <= sh[33:0];
				q_q <= {q_q[54:0], 1'b0};
			end
		end
	end
endmodule

// ===== sv/kalman_angle_bias_filter_core.sv =====
`timescale 1ns / 1ps
// Two-state angle/gyro-bias Kalman filter. An accepted item takes ten passes
// through one shared 34x32 multiplier with rounding and saturation, plus two
// 56-step restoring divisions for the gains (skipped, with both gains zero,
// when the innovation covariance is zero); in_stall stays high from
// acceptance until angle_estimate is taken.
module kalman_angle_bias_filter_core import kabf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [NoiseW-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [31:0] measured_angle,
	input  logic signed [31:0] measured_rate,
	input  logic [23:0] time_step,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [31:0] angle_estimate
);
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001, S_MUL = 6'b000010, S_DIV0 = 6'b000100,
		S_DIV1 = 6'b001000, S_UPD = 6'b010000, S_OUT = 6'b100000
	} state_t;

	state_t state_q;
	logic [4:0] step_q;
	logic [NoiseW-1:0] qa_q, qb_q, r_q;
	logic signed [31:0] ang_q, bias_q, p00_q, p01_q, p10_q, p11_q;
	logic signed [31:0] meas_q, rate_q, n00_q, n01_q, n10_q, n11_q;
	logic signed [31:0] k0_q, k1_q, y_q;
	logic [23:0] dt_q;
	logic signed [33:0] t_q;
	logic signed [33:0] s_q;
	logic signed [33:0] ma;
	logic signed [31:0] mb;
	logic signed [65:0] prod, rs;
	logic div_start, div_done;
	logic signed [31:0] div_num, div_q;

	always_comb begin
		ma = $signed({10'd0, dt_q});
		mb = rate_q;
		case (step_q)
			5'd0: mb = rate_q;
			5'd1: mb = p11_q;
			5'd2: begin ma = t_q; mb = $signed({8'd0, dt_q}); end
			5'd3: mb = $signed({8'd0, qb_q});
			5'd4: begin ma = {{2{k0_q[31]}}, k0_q}; mb = y_q; end
			5'd5: begin ma = {{2{k1_q[31]}}, k1_q}; mb = y_q; end
			5'd6: begin ma = {{2{k0_q[31]}}, k0_q}; mb = n00_q; end
			5'd7: begin ma = {{2{k0_q[31]}}, k0_q}; mb = n01_q; end
			5'd8: begin ma = {{2{k1_q[31]}}, k1_q}; mb = n00_q; end
			5'd9: begin ma = {{2{k1_q[31]}}, k1_q}; mb = n01_q; end
			default: mb = rate_q;
		endcase
	end

	assign prod = 66'(ma * mb);
	assign rs = rscale(prod);
	assign div_num = (state_q == S_DIV0) ? n00_q : n10_q;

	kabf_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(s_q), .done(div_done), .quo(div_q)
	);

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign angle_estimate = ang_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= '0;
			div_start <= 1'b0;
			qa_q <= AngleNoiseRst;
			qb_q <= BiasNoiseRst;
			r_q <= MeasNoiseRst;
			ang_q <= '0; bias_q <= '0;
			p00_q <= '0; p01_q <= '0; p10_q <= '0; p11_q <= '0;
		end else begin
			div_start <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					RegAngleNoise: qa_q <= cfg_data;
					RegBiasNoise: qb_q <= cfg_data;
					RegMeasNoise: r_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: if (in_valid) begin
					meas_q <= measured_angle;
					dt_q <= time_step;
					rate_q <= sat32(66'(measured_rate) - 66'(bias_q));
					step_q <= 5'd0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					step_q <= step_q + 5'd1;
					case (step_q)
						5'd0: ang_q <= sat32(66'(ang_q) + rs);
						5'd1: begin
							t_q <= 34'(rs - 66'(p01_q) - 66'(p10_q)
								+ 66'($signed({1'b0, qa_q})));
							n01_q <= sat32(66'(p01_q) - rs);
							n10_q <= sat32(66'(p10_q) - rs);
						end
						5'd2: n00_q <= sat32(66'(p00_q) + rs);
						5'd3: begin
							n11_q <= sat32(66'(p11_q) + rs);
							s_q <= 34'(n00_q) + 34'($signed({1'b0, r_q}));
							if (34'(n00_q) + 34'($signed({1'b0, r_q})) == 34'sd0)
							begin
								k0_q <= '0; k1_q <= '0;
								state_q <= S_UPD;
								step_q <= 5'd4;
							end else begin
								div_start <= 1'b1;
								state_q <= S_DIV0;
							end
						end
						5'd4: ang_q <= sat32(66'(ang_q) + rs);
						5'd5: bias_q <= sat32(66'(bias_q) + rs);
						5'd6: p00_q <= sat32(66'(n00_q) - rs);
						5'd7: p01_q <= sat32(66'(n01_q) - rs);
						5'd8: p10_q <= sat32(66'(n10_q) - rs);
						5'd9: begin
							p11_q <= sat32(66'(n11_q) - rs);
							state_q <= S_OUT;
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_DIV0: if (div_done) begin
					k0_q <= div_q;
					div_start <= 1'b1;
					state_q <= S_DIV1;
				end
				S_DIV1: if (div_done) begin
					k1_q <= div_q;
					state_q <= S_UPD;
				end
				S_UPD: begin
					y_q <= sat32(66'(meas_q) - 66'(ang_q));
					step_q <= 5'd4;
					state_q <= S_MUL;
				end
				S_OUT: if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
